@@ src/smx_pkg.sv @@
// ----------------------------------------------------------------------------
// smx_pkg: shared definitions for the ten-class softmax block
// Field widths, fixed-point constants and the 2^f table generator.
// ----------------------------------------------------------------------------
package smx_pkg;

    // Field widths.
    localparam int LOGIT_W   = 16;
    localparam int PROB_W    = 16;
    localparam int TERM_W    = 16;
    localparam int CLASS_W   = 4;
    localparam int SUM_W     = 20;

    // Default configuration handed to the top level.
    localparam int DEF_NUM_CLASSES    = 10;
    localparam int DEF_EXP_TABLE_SIZE = 64;

    // Fixed-point constants.
    localparam logic [15:0] LOG2E_Q15 = 16'd47274;
    localparam longint unsigned LN2_Q30 = 64'd744261118;
    localparam int FRAC_BITS = 23;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam logic signed [LOGIT_W-1:0] LOGIT_MIN = {1'b1, {(LOGIT_W-1){1'b0}}};

    // Quotient bits produced by the divider: the quotient never exceeds 2^16.
    localparam int QUO_W = 17;

    // e^x for x in Q30 (0 <= x < ln2 scaled), as a rounded Q1.15 value.
    // Evaluated only at elaboration to fill the constant table.
    function automatic logic [15:0] pow2_q15(input logic [63:0] x);
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] v;
        term = 64'd1 << 30;
        acc  = term;
        for (int i = 1; i < 30; i++)
        begin
            if (term != 64'd0)
            begin
                term = ((term * x) >> 30) / 64'(i);
                acc  = acc + term;
            end
        end
        v = (acc + (64'd1 << 14)) >> 15;
        if (v > 64'd65535)
        begin
            v = 64'd65535;
        end
        return v[15:0];
    endfunction

endpackage

@@ src/smx_ram.sv @@
// ----------------------------------------------------------------------------
// smx_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module smx_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

@@ src/smx_exp_unit.sv @@
// ----------------------------------------------------------------------------
// smx_exp_unit: pipelined exponential term unit
// Computes e^(logit - max) in Q1.15 as 2^-(d*log2e) in three stages.
// ----------------------------------------------------------------------------
module smx_exp_unit
    import smx_pkg::*;
#(
    parameter int EXP_TABLE_SIZE = DEF_EXP_TABLE_SIZE
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic signed [LOGIT_W-1:0] logit,
    input  logic signed [LOGIT_W-1:0] max_logit,
    output logic                      out_valid,
    output logic [TERM_W-1:0]         term
);

    localparam int IDX_W  = $clog2(EXP_TABLE_SIZE);
    localparam int PROD_W = FRAC_BITS + $clog2(EXP_TABLE_SIZE + 1);

    // Constant 2^(k/size) table, built at elaboration.
    logic [15:0] pow2_rom [EXP_TABLE_SIZE];

    for (genvar k = 0; k < EXP_TABLE_SIZE; k++)
    begin : gen_rom
        localparam logic [63:0] X_Q30 = (64'(k) * LN2_Q30) / EXP_TABLE_SIZE;
        localparam logic [15:0] ENTRY = pow2_q15(X_Q30);
        assign pow2_rom[k] = ENTRY;
    end

    logic              v1_reg, v2_reg, v3_reg;
    logic [31:0]       t_reg;
    logic              big_reg;
    logic [3:0]        shift_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [TERM_W-1:0] term_reg;

    // Stage one: distance from the maximum, scaled by log2(e).
    logic signed [LOGIT_W:0] diff;
    logic [15:0]             gap;
    assign diff = {max_logit[LOGIT_W-1], max_logit} - {logit[LOGIT_W-1], logit};
    assign gap  = diff[15:0];

    // Stage two: split into a shift and a table index.
    logic [8:0]           int_part;
    logic [FRAC_BITS-1:0] frac_in;
    logic                 frac_zero;
    logic [9:0]           shift_full;
    logic [FRAC_BITS:0]   frac_comp;
    logic [FRAC_BITS-1:0] frac_sel;
    logic [PROD_W-1:0]    idx_prod;

    assign int_part   = t_reg[31:FRAC_BITS];
    assign frac_in    = t_reg[FRAC_BITS-1:0];
    assign frac_zero  = (frac_in == '0);
    assign shift_full = frac_zero ? {1'b0, int_part} : ({1'b0, int_part} + 10'd1);
    assign frac_comp  = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_in};
    assign frac_sel   = frac_zero ? '0 : frac_comp[FRAC_BITS-1:0];
    assign idx_prod   = PROD_W'(frac_sel) * PROD_W'(EXP_TABLE_SIZE);

    // Valid pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Data pipeline; stage three reads the table and applies the shift.
    always_ff @(posedge clk)
    begin
        t_reg     <= 32'(gap) * 32'(LOG2E_Q15);
        big_reg   <= (shift_full[9:4] != '0);
        shift_reg <= shift_full[3:0];
        idx_reg   <= idx_prod[FRAC_BITS +: IDX_W];
        term_reg  <= big_reg ? '0 : (pow2_rom[idx_reg] >> shift_reg);
    end

    assign out_valid = v3_reg;
    assign term      = term_reg;

endmodule

@@ src/smx_divider.sv @@
// ----------------------------------------------------------------------------
// smx_divider: bit-serial restoring divider
// Computes (term << 16) / sum, one quotient bit a cycle, saturated to 16 bits.
// ----------------------------------------------------------------------------
module smx_divider
    import smx_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TERM_W-1:0] num,
    input  logic [SUM_W-1:0]  den,
    output logic              done,
    output logic [PROB_W-1:0] quotient
);

    logic [SUM_W-1:0] rem_reg;
    logic [QUO_W-1:0] dvd_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [SUM_W-1:0] den_reg;
    logic [4:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;

    // Trial subtraction of one step.
    logic [SUM_W:0] trial;
    logic [SUM_W:0] diff;
    logic           ge;
    assign trial = {rem_reg, dvd_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    // Step control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 5'(QUO_W);
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            cnt_reg  <= cnt_reg - 5'd1;
            run_reg  <= (cnt_reg != 5'd1);
            done_reg <= (cnt_reg == 5'd1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath. The upper quotient bits are zero because sum >= term,
    // so the partial remainder starts from the top fifteen dividend bits.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= SUM_W'(num[TERM_W-1:1]);
            dvd_reg <= {num[0], 16'd0};
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
            dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    // Saturation at 65535 and the guard against a zero sum.
    always_comb
    begin
        if (den_reg == '0)
        begin
            quotient = '0;
        end
        else if (quo_reg[QUO_W-1])
        begin
            quotient = {PROB_W{1'b1}};
        end
        else
        begin
            quotient = quo_reg[PROB_W-1:0];
        end
    end

    assign done = done_reg;

endmodule

@@ src/softmax_ten_class.sv @@
// ----------------------------------------------------------------------------
// softmax_ten_class: softmax over a set of fixed-point logits
// Loads a set of signed Q7.8 logits and returns one Q0.16 probability each.
// ----------------------------------------------------------------------------
// Usage:
//   A request is accepted at a rising edge with start high and busy low; it
//   carries one logit. Logits load one per cycle in class order. After the
//   last logit of a set, busy stays high while the block works the set.
//   The block computes every exponential term through a three-stage unit,
//   then divides each term by the sum in a bit-serial divider, one class
//   at a time; each class takes one RAM read, one load, seventeen quotient
//   steps and one output register before the next class is started.
//   Each probability appears for one cycle with done high, together with
//   class_index and last_class; the receiver cannot stall and must take it.
//   The block leaves busy low again in the cycle after the last divide, so
//   the next set may load while the final probability is shown.
//   Reset clears the sequencer, the running maximum and the sum; the logit
//   and term stores are not cleared, every entry being written before use.
// ----------------------------------------------------------------------------
module softmax_ten_class
    import smx_pkg::*;
#(
    parameter int NUM_CLASSES    = DEF_NUM_CLASSES,
    parameter int EXP_TABLE_SIZE = DEF_EXP_TABLE_SIZE
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [LOGIT_W-1:0] logit,
    output logic                      done,
    output logic [PROB_W-1:0]         probability,
    output logic [CLASS_W-1:0]        class_index,
    output logic                      last_class
);

    localparam int CNT_W = $clog2(NUM_CLASSES);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(NUM_CLASSES - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_EXP   = 5'b00010,
        S_RD    = 5'b00100,
        S_START = 5'b01000,
        S_DIV   = 5'b10000
    } state_t;

    state_t                     state_reg, state_next;
    logic [CNT_W-1:0]           load_cnt_reg, load_cnt_next;
    logic [CNT_W-1:0]           iss_cnt_reg, iss_cnt_next;
    logic                       iss_on_reg, iss_on_next;
    logic                       rd_valid_reg, rd_valid_next;
    logic [CNT_W-1:0]           wr_cnt_reg, wr_cnt_next;
    logic [CNT_W-1:0]           cls_cnt_reg, cls_cnt_next;
    logic signed [LOGIT_W-1:0]  max_reg, max_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic                       done_reg, done_next;
    logic [PROB_W-1:0]          prob_reg;
    logic [CLASS_W-1:0]         idx_reg;
    logic                       last_reg;

    logic                       accept;
    logic signed [LOGIT_W-1:0]  logit_rd;
    logic                       exp_valid;
    logic [TERM_W-1:0]          exp_term;
    logic [TERM_W-1:0]          term_rd;
    logic                       div_done;
    logic [PROB_W-1:0]          div_q;
    logic [SUM_W:0]             sum_wide;

    assign busy   = (state_reg != S_LOAD);
    assign accept = start && !busy;

    // Logit store.
    smx_ram #(
        .WIDTH (LOGIT_W),
        .DEPTH (NUM_CLASSES)
    ) u_logit_ram (
        .clk     (clk),
        .wr_en   (accept),
        .wr_addr (load_cnt_reg),
        .wr_data (logit),
        .rd_addr (iss_cnt_reg),
        .rd_data (logit_rd)
    );

    // Exponential term unit.
    smx_exp_unit #(
        .EXP_TABLE_SIZE (EXP_TABLE_SIZE)
    ) u_exp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .logit     (logit_rd),
        .max_logit (max_reg),
        .out_valid (exp_valid),
        .term      (exp_term)
    );

    // Exponential term store.
    smx_ram #(
        .WIDTH (TERM_W),
        .DEPTH (NUM_CLASSES)
    ) u_term_ram (
        .clk     (clk),
        .wr_en   (exp_valid),
        .wr_addr (wr_cnt_reg),
        .wr_data (exp_term),
        .rd_addr (cls_cnt_reg),
        .rd_data (term_rd)
    );

    // Shared divider.
    smx_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_START),
        .num      (term_rd),
        .den      (sum_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // Saturating sum of the terms.
    assign sum_wide = {1'b0, sum_reg} + (SUM_W + 1)'(exp_term);

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        iss_cnt_next  = iss_cnt_reg;
        iss_on_next   = iss_on_reg;
        rd_valid_next = 1'b0;
        wr_cnt_next   = wr_cnt_reg;
        cls_cnt_next  = cls_cnt_reg;
        max_next      = max_reg;
        sum_next      = sum_reg;
        done_next     = 1'b0;

        unique case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (logit > max_reg)
                    begin
                        max_next = logit;
                    end
                    if (load_cnt_reg == LAST_IDX)
                    begin
                        load_cnt_next = '0;
                        iss_cnt_next  = '0;
                        iss_on_next   = 1'b1;
                        wr_cnt_next   = '0;
                        sum_next      = '0;
                        state_next    = S_EXP;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + CNT_ONE;
                    end
                end
            end
            S_EXP:
            begin
                // Issue one store read a cycle into the exponential unit.
                if (iss_on_reg)
                begin
                    rd_valid_next = 1'b1;
                    if (iss_cnt_reg == LAST_IDX)
                    begin
                        iss_on_next = 1'b0;
                    end
                    else
                    begin
                        iss_cnt_next = iss_cnt_reg + CNT_ONE;
                    end
                end
                // Collect the terms and accumulate the sum.
                if (exp_valid)
                begin
                    sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
                    if (wr_cnt_reg == LAST_IDX)
                    begin
                        cls_cnt_next = '0;
                        state_next   = S_RD;
                    end
                    else
                    begin
                        wr_cnt_next = wr_cnt_reg + CNT_ONE;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    done_next = 1'b1;
                    if (cls_cnt_reg == LAST_IDX)
                    begin
                        max_next   = LOGIT_MIN;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cls_cnt_next = cls_cnt_reg + CNT_ONE;
                        state_next   = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            load_cnt_reg <= '0;
            iss_cnt_reg  <= '0;
            iss_on_reg   <= 1'b0;
            rd_valid_reg <= 1'b0;
            wr_cnt_reg   <= '0;
            cls_cnt_reg  <= '0;
            max_reg      <= LOGIT_MIN;
            sum_reg      <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            iss_cnt_reg  <= iss_cnt_next;
            iss_on_reg   <= iss_on_next;
            rd_valid_reg <= rd_valid_next;
            wr_cnt_reg   <= wr_cnt_next;
            cls_cnt_reg  <= cls_cnt_next;
            max_reg      <= max_next;
            sum_reg      <= sum_next;
            done_reg     <= done_next;
        end
    end

    // Result registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DIV && div_done)
        begin
            prob_reg <= div_q;
            idx_reg  <= CLASS_W'(cls_cnt_reg);
            last_reg <= (cls_cnt_reg == LAST_IDX);
        end
    end

    assign done        = done_reg;
    assign probability = prob_reg;
    assign class_index = idx_reg;
    assign last_class  = last_reg;

    // A result always follows a cycle of work.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> $past(busy))
        else $error("result strobe without preceding work");

    // Results are spaced by the divider; two strobes never touch.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("back-to-back result strobes");

    // The last mark comes with the final class number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && last_class) |-> (class_index == CLASS_W'(NUM_CLASSES - 1)))
        else $error("last mark on the wrong class");

    // The maximum term keeps the sum from ever being zero at divide time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (sum_reg != '0))
        else $error("zero exponential sum");

endmodule
